FILE: src/swmms_pkg.sv
package swmms_pkg;

   localparam int CFG_BITS     = 7;
   localparam int FIELD_W      = 32;
   localparam int TOTAL_W      = 64;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_BACK_RD,
      ST_BACK_CHK,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_back;
      logic exp_step;
      logic back_step;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic any_expired;
      logic any_dominated;
      logic out_free;
   } status_type;

endpackage

FILE: src/swmms_ram.sv
module swmms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/swmms_ctrl.sv
module swmms_ctrl
   import swmms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXP_RD;
         end
         ST_EXP_RD: begin
            state_in = ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            state_in = status.any_expired ? ST_EXP_RD : ST_BACK_RD;
         end
         ST_BACK_RD: begin
            state_in = ST_BACK_CHK;
         end
         ST_BACK_CHK: begin
            state_in = status.any_dominated ? ST_BACK_RD : ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.rd_back   = state_ff inside {ST_BACK_RD, ST_BACK_CHK};
      cmd.exp_step  = (state_ff == ST_EXP_CHK);
      cmd.back_step = (state_ff == ST_BACK_CHK);
      cmd.push      = (state_ff == ST_PUSH) && status.out_free;
   end

endmodule

FILE: src/swmms_datapath.sv
module swmms_datapath
   import swmms_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_write_enable,
   input  logic [CFG_BITS-1:0]       csr_write_data,
   input  logic signed [FIELD_W-1:0] req_sample,
   input  logic                      req_last_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_window_min,
   output logic signed [FIELD_W-1:0] rsp_window_max,
   output logic                      rsp_window_full,
   output logic signed [TOTAL_W-1:0] rsp_running_total,
   output logic                      rsp_stream_done,
   output logic                      rsp_short_stream
);

   localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WW  = $clog2(MAX_WINDOW + 1);
   localparam int PW  = $clog2(MAX_WINDOW) + 1;
   localparam int EW  = SAMPLE_BITS + PW;
   localparam int SW  = (WW > CFG_BITS) ? WW : CFG_BITS;
   localparam int XW  = AW + 2;
   localparam int DW  = SAMPLE_BITS + 1;
   localparam int NQ  = 2;

   logic [CFG_BITS-1:0]           window_length_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          last_ff;
   logic [PW-1:0]                 pos_ff;
   logic [WW-1:0]                 seen_ff;
   logic signed [TOTAL_W-1:0]     sum_ff;
   logic                          rsp_valid_ff;

   logic signed [FIELD_W-1:0]     rsp_min_ff, rsp_max_ff;
   logic                          rsp_full_ff, rsp_done_ff, rsp_short_ff;
   logic signed [TOTAL_W-1:0]     rsp_total_ff;

   logic [SW-1:0]                 cfg_ext;
   logic [WW-1:0]                 w_eff;
   logic [WW-1:0]                 seen_in;
   logic                          full;
   logic signed [DW-1:0]          pair_sum;
   logic signed [TOTAL_W:0]       sum_wide;
   logic signed [TOTAL_W-1:0]     sum_sat;
   logic signed [TOTAL_W-1:0]     total_in;

   logic [NQ-1:0]                 expired_q;
   logic [NQ-1:0]                 dominated_q;
   logic signed [SAMPLE_BITS-1:0] front_q [NQ];

   // effective window: zero reads as one, clamp to capacity
   always_comb begin
      cfg_ext = SW'(window_length_ff);
      if (cfg_ext == '0) begin
         w_eff = WW'(1);
      end else if (cfg_ext > SW'(MAX_WINDOW)) begin
         w_eff = WW'(MAX_WINDOW);
      end else begin
         w_eff = WW'(cfg_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample[SAMPLE_BITS-1:0];
         last_ff   <= req_last_sample;
      end
   end

   for (genvar gq = 0; gq < NQ; gq++) begin : g_queue
      logic [AW-1:0]                 head_ff;
      logic [WW-1:0]                 count_ff;
      logic signed [SAMPLE_BITS-1:0] front_val_ff;
      logic [AW-1:0]                 head_inc;
      logic [XW-1:0]                 back_sum, push_sum;
      logic [AW-1:0]                 back_idx, push_idx, rd_addr;
      logic [EW-1:0]                 rd_data;
      logic signed [SAMPLE_BITS-1:0] entry_val;
      logic [PW-1:0]                 entry_pos, age;
      logic                          worse;

      always_comb begin
         head_inc  = (XW'(head_ff) == XW'(MAX_WINDOW - 1)) ? '0 : head_ff + AW'(1);
         back_sum  = XW'(head_ff) + XW'(count_ff) - XW'(1);
         back_idx  = (back_sum >= XW'(MAX_WINDOW)) ? AW'(back_sum - XW'(MAX_WINDOW))
                                                   : AW'(back_sum);
         push_sum  = XW'(head_ff) + XW'(count_ff);
         push_idx  = (push_sum >= XW'(MAX_WINDOW)) ? AW'(push_sum - XW'(MAX_WINDOW))
                                                   : AW'(push_sum);
         rd_addr   = cmd.rd_back ? back_idx : head_ff;
         entry_val = rd_data[EW-1:PW];
         entry_pos = rd_data[PW-1:0];
         age       = pos_ff - entry_pos;
         if (gq == 0) begin
            worse = (entry_val >= sample_ff);
         end else begin
            worse = (entry_val <= sample_ff);
         end
         expired_q[gq]   = (count_ff != '0) && (age >= PW'(w_eff));
         dominated_q[gq] = (count_ff != '0) && worse;
         front_q[gq]     = (count_ff == '0) ? sample_ff : front_val_ff;
      end

      swmms_ram #(
         .WIDTH(EW),
         .DEPTH(MAX_WINDOW)
      ) u_ram (
         .clock  (clock),
         .wr_en  (cmd.push),
         .wr_addr(push_idx),
         .wr_data({sample_ff, pos_ff}),
         .rd_addr(rd_addr),
         .rd_data(rd_data)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            head_ff  <= '0;
            count_ff <= '0;
         end else if (cmd.exp_step) begin
            if (expired_q[gq]) begin
               head_ff  <= head_inc;
               count_ff <= count_ff - WW'(1);
            end
         end else if (cmd.back_step) begin
            if (dominated_q[gq]) count_ff <= count_ff - WW'(1);
         end else if (cmd.push) begin
            if (last_ff) begin
               head_ff  <= '0;
               count_ff <= '0;
            end else begin
               count_ff <= count_ff + WW'(1);
            end
         end
      end

      // surviving head entry seen on the final expiry check
      always_ff @(posedge clock) begin
         if (cmd.exp_step && !expired_q[gq] && count_ff != '0) begin
            front_val_ff <= entry_val;
         end
      end
   end

   always_comb begin
      status.any_expired   = |expired_q;
      status.any_dominated = |dominated_q;
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      seen_in  = (seen_ff == WW'(MAX_WINDOW)) ? seen_ff : seen_ff + WW'(1);
      full     = (seen_in >= w_eff);
      pair_sum = DW'(front_q[0]) + DW'(front_q[1]);
      sum_wide = (TOTAL_W + 1)'(sum_ff) + (TOTAL_W + 1)'(pair_sum);
      if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
         sum_sat = sum_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                     : {1'b0, {(TOTAL_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[TOTAL_W-1:0];
      end
      total_in = full ? sum_sat : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         pos_ff       <= last_ff ? '0 : pos_ff + PW'(1);
         seen_ff      <= last_ff ? '0 : seen_in;
         sum_ff       <= last_ff ? '0 : total_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_min_ff   <= FIELD_W'(front_q[0]);
         rsp_max_ff   <= FIELD_W'(front_q[1]);
         rsp_full_ff  <= full;
         rsp_total_ff <= total_in;
         rsp_done_ff  <= last_ff;
         rsp_short_ff <= last_ff && !full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_min    = rsp_min_ff;
   assign rsp_window_max    = rsp_max_ff;
   assign rsp_window_full   = rsp_full_ff;
   assign rsp_running_total = rsp_total_ff;
   assign rsp_stream_done   = rsp_done_ff;
   assign rsp_short_stream  = rsp_short_ff;

endmodule

FILE: src/sliding_window_min_max_sum_core.sv
// Sliding window minimum / maximum with a saturating running sum of min + max.
//
// Request channel (req_valid / req_ready): one signed sample per request,
// req_last_sample marks the end of a stream. Response channel (rsp_valid /
// rsp_ready): exactly one response per request, in order.
// csr_write_enable / csr_write_data set the window length (reset value 3);
// write it only while no request is in flight.
//
// Timing: a request is taken in the idle state, then passes expiry check,
// back-of-queue check and push; both queues run these loops side by side.
// Each front entry retired adds one more expiry step and each back entry
// popped one more back step, each loop running as long as the busier queue
// needs. The registered read of the queue RAMs splits each loop step into a
// read state and a check state. rsp_valid is set in the output register by
// the push.
// The response sits in an output register: a stalled receiver holds it while
// the next request is accepted and worked on; only the push waits for room.
// Reset (synchronous) empties the queues and clears all stream state; the
// last sample of a stream does the same after its response is formed.
module sliding_window_min_max_sum_core
   import swmms_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_sample,
   input  logic                      req_last_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_window_min,
   output logic signed [FIELD_W-1:0] rsp_window_max,
   output logic                      rsp_window_full,
   output logic signed [TOTAL_W-1:0] rsp_running_total,
   output logic                      rsp_stream_done,
   output logic                      rsp_short_stream,
   input  logic                      csr_write_enable,
   input  logic [CFG_BITS-1:0]       csr_write_data
);

   cmd_type    cmd;
   status_type status;

   swmms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   swmms_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_full  (rsp_window_full),
      .rsp_running_total(rsp_running_total),
      .rsp_stream_done  (rsp_stream_done),
      .rsp_short_stream (rsp_short_stream)
   );

endmodule

FILE: src/swmms_checker.sv
module swmms_checker
   import swmms_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [FIELD_W-1:0] rsp_window_min,
   input logic signed [FIELD_W-1:0] rsp_window_max,
   input logic                      rsp_window_full,
   input logic signed [TOTAL_W-1:0] rsp_running_total,
   input logic                      rsp_stream_done,
   input logic                      rsp_short_stream
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_min <= rsp_window_max)
      else $error("window minimum above maximum");

   a_short_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_stream |-> rsp_stream_done && !rsp_window_full)
      else $error("short stream flag without end of stream or with full window");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_total))
      else $error("stalled response changed");

endmodule

bind sliding_window_min_max_sum_core swmms_checker u_checker (.*);

FILE: bench/tb_sliding_window_min_max_sum_core.sv
`timescale 1ns / 100ps

module tb_sliding_window_min_max_sum_core;
   import swmms_pkg::*;

   localparam int DEPTH       = 64;
   localparam int LO_SIDE     = 0;
   localparam int HI_SIDE     = 1;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 20;

   typedef struct {
      logic signed [FIELD_W-1:0] wmin;
      logic signed [FIELD_W-1:0] wmax;
      logic                      full;
      logic signed [TOTAL_W-1:0] total;
      logic                      done;
      logic                      short_flag;
   } window_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [FIELD_W-1:0] req_sample = '0;
   logic                      req_last_sample = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [FIELD_W-1:0] rsp_window_min;
   logic signed [FIELD_W-1:0] rsp_window_max;
   logic                      rsp_window_full;
   logic signed [TOTAL_W-1:0] rsp_running_total;
   logic                      rsp_stream_done;
   logic                      rsp_short_stream;
   logic                      csr_write_enable = 1'b0;
   logic [CFG_BITS-1:0]       csr_write_data = '0;

   // window model state
   logic [CFG_BITS-1:0]       window_len_reg = WINDOW_RESET;
   logic signed [FIELD_W-1:0] deque_val [2][DEPTH];
   logic [31:0]               deque_pos [2][DEPTH];
   int                        deque_head [2];
   int                        deque_cnt [2];
   logic [31:0]               position;
   logic signed [TOTAL_W-1:0] run_sum;
   int                        seen_count;

   window_result_type         pending_results [$];
   int                        error_count = 0;
   int                        burst_left = 0;
   int                        stall_cycles = 0;
   int                        rx_cycle = 0;

   sliding_window_min_max_sum_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_window_min    (rsp_window_min),
      .rsp_window_max    (rsp_window_max),
      .rsp_window_full   (rsp_window_full),
      .rsp_running_total (rsp_running_total),
      .rsp_stream_done   (rsp_stream_done),
      .rsp_short_stream  (rsp_short_stream),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int clamp_window(input logic [CFG_BITS-1:0] len);
      if (len == 0) begin
         return 1;
      end
      if (len > DEPTH) begin
         return DEPTH;
      end
      return int'(len);
   endfunction

   task automatic clear_stream();
      deque_head[LO_SIDE] = 0;
      deque_head[HI_SIDE] = 0;
      deque_cnt[LO_SIDE]  = 0;
      deque_cnt[HI_SIDE]  = 0;
      position            = '0;
      run_sum             = '0;
      seen_count          = 0;
   endtask

   task automatic advance_deque(input int side, input logic signed [FIELD_W-1:0] v,
                                input int w);
      int                        idx;
      logic signed [FIELD_W-1:0] back;
      logic                      drop;
      while (deque_cnt[side] > 0 &&
             (position - deque_pos[side][deque_head[side]]) >= 32'(w)) begin
         deque_head[side] = (deque_head[side] + 1) % DEPTH;
         deque_cnt[side]--;
      end
      while (deque_cnt[side] > 0) begin
         idx  = (deque_head[side] + deque_cnt[side] - 1) % DEPTH;
         back = deque_val[side][idx];
         drop = (side == LO_SIDE) ? (back >= v) : (back <= v);
         if (!drop) begin
            break;
         end
         deque_cnt[side]--;
      end
      if (deque_cnt[side] >= DEPTH) begin
         deque_head[side] = (deque_head[side] + 1) % DEPTH;
         deque_cnt[side]--;
      end
      idx                   = (deque_head[side] + deque_cnt[side]) % DEPTH;
      deque_val[side][idx]  = v;
      deque_pos[side][idx]  = position;
      deque_cnt[side]++;
   endtask

   task automatic predict_window(input logic signed [FIELD_W-1:0] s, input logic last);
      window_result_type         r;
      int                        w;
      logic signed [TOTAL_W-1:0] term;
      logic signed [TOTAL_W-1:0] sum;
      w = clamp_window(window_len_reg);
      advance_deque(LO_SIDE, s, w);
      advance_deque(HI_SIDE, s, w);
      if (seen_count < DEPTH) begin
         seen_count++;
      end
      r.full = (seen_count >= w);
      r.wmin = deque_val[LO_SIDE][deque_head[LO_SIDE]];
      r.wmax = deque_val[HI_SIDE][deque_head[HI_SIDE]];
      if (r.full) begin
         term = r.wmin;
         term = term + r.wmax;
         sum  = run_sum + term;
         if (run_sum[TOTAL_W-1] == term[TOTAL_W-1] && sum[TOTAL_W-1] != term[TOTAL_W-1]) begin
            run_sum = term[TOTAL_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                      : {1'b0, {(TOTAL_W-1){1'b1}}};
         end else begin
            run_sum = sum;
         end
      end
      r.total      = run_sum;
      r.done       = last;
      r.short_flag = last && !r.full;
      position     = position + 1;
      if (last) begin
         clear_stream();
      end
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic push_request(input logic signed [FIELD_W-1:0] s, input logic last);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      predict_window(s, last);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_window(input logic [CFG_BITS-1:0] len);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_len_reg = len;
   endtask

   task automatic test_default_window();
      push_request(32'sd0, 1'b0);
      push_request(32'sh8000_0000, 1'b0);
      push_request(32'sh7FFF_FFFF, 1'b0);
      push_request(-32'sd1, 1'b0);
      push_request(32'sd5, 1'b1);
   endtask

   task automatic test_short_stream();
      push_request(32'sd7, 1'b0);
      push_request(-32'sd7, 1'b1);
      push_request(32'sd42, 1'b1);
   endtask

   task automatic test_equal_values();
      repeat (3) push_request(32'sd4, 1'b0);
      push_request(32'sd4, 1'b1);
   endtask

   task automatic test_window_extremes();
      set_window(7'd0);
      push_request(32'sd5, 1'b0);
      push_request(-32'sd5, 1'b1);
      set_window(7'd127);
      push_request(32'sd1, 1'b0);
      push_request(32'sd2, 1'b0);
      push_request(32'sd3, 1'b1);
      set_window(7'd64);
      push_request(32'sd9, 1'b1);
      set_window(7'd1);
      push_request(32'sh8000_0000, 1'b1);
   endtask

   task automatic test_window_change();
      set_window(7'd4);
      push_request(32'sd10, 1'b0);
      push_request(32'sd20, 1'b0);
      push_request(32'sd30, 1'b0);
      set_window(7'd2);
      push_request(32'sd5, 1'b0);
      push_request(32'sd40, 1'b1);
   endtask

   task automatic test_drain_pause();
      int k;
      set_window(7'd5);
      for (k = 0; k < 10; k++) begin
         push_request($urandom, 1'b0);
      end
      wait_drained();
      for (k = 0; k < 10; k++) begin
         push_request($urandom, k == 9);
      end
   endtask

   task automatic test_random_streams(input int target);
      int                        sent;
      int                        len;
      int                        eff;
      int                        split;
      int                        mode;
      int                        k;
      logic [CFG_BITS-1:0]       new_len;
      logic signed [FIELD_W-1:0] v;
      logic signed [FIELD_W-1:0] ramp;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0: new_len = 7'd0;
               1: new_len = 7'($urandom_range(65, 127));
               2: new_len = 7'd64;
               3, 4, 5: new_len = 7'($urandom_range(1, 8));
               default: new_len = 7'($urandom_range(1, 64));
            endcase
            set_window(new_len);
         end
         eff = clamp_window(window_len_reg);
         if ($urandom_range(0, 9) == 0) begin
            len = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
         end else begin
            len = $urandom_range(eff, 2 * eff + 20);
         end
         split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
         mode  = $urandom_range(0, 4);
         ramp  = $urandom;
         for (k = 0; k < len; k++) begin
            if (k == split) begin
               set_window(($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(1, 64)));
            end
            case (mode)
               0: v = $urandom;
               1: v = 32'($urandom_range(0, 6)) - 32'sd3;
               2: begin
                  ramp = ramp + 32'($urandom_range(0, 3));
                  v    = ramp;
               end
               3: begin
                  // falling run with rare jumps to the top
                  if ($urandom_range(0, 19) == 0) begin
                     v = 32'sh7FFF_FFFF;
                  end else begin
                     ramp = ramp - 32'($urandom_range(0, 3));
                     v    = ramp;
                  end
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: v = 32'sh8000_0000;
                     1: v = 32'sh7FFF_FFFF;
                     2: v = 32'sd0;
                     3: v = -32'sd1;
                     default: v = $urandom;
                  endcase
               end
            endcase
            push_request(v, k == len - 1);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 300) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((rx_cycle % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: min %0d max %0d total %0d",
                   rsp_window_min, rsp_window_max, rsp_running_total);
            error_count++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_window_min !== want.wmin) begin
               $error("window_min: expected %0d, got %0d", want.wmin, rsp_window_min);
               error_count++;
            end
            if (rsp_window_max !== want.wmax) begin
               $error("window_max: expected %0d, got %0d", want.wmax, rsp_window_max);
               error_count++;
            end
            if (rsp_window_full !== want.full) begin
               $error("window_full: expected %0d, got %0d", want.full, rsp_window_full);
               error_count++;
            end
            if (rsp_running_total !== want.total) begin
               $error("running_total: expected %0d, got %0d", want.total, rsp_running_total);
               error_count++;
            end
            if (rsp_stream_done !== want.done) begin
               $error("stream_done: expected %0d, got %0d", want.done, rsp_stream_done);
               error_count++;
            end
            if (rsp_short_stream !== want.short_flag) begin
               $error("short_stream: expected %0d, got %0d", want.short_flag,
                      rsp_short_stream);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clear_stream();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_window();
      test_short_stream();
      test_equal_values();
      test_window_extremes();
      test_window_change();
      test_drain_pause();
      test_random_streams(1900);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
